@@ rtl/ps2_mouse_packet_cursor_macros.svh @@
// Assertion helpers for the cursor block.
`ifndef PS2_MOUSE_PACKET_CURSOR_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cursor block assertion failed");

// Next-cycle implication, disabled during reset.
`define PMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cursor block assertion failed");

`endif

@@ rtl/ps2mc_pkg.sv @@
package ps2mc_pkg;

    localparam int COORD_BITS_DEF = 10;

    localparam int REG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int BYTE_W    = 8;
    localparam int MAG_W     = 9;
    localparam int PROD_W    = 17;
    localparam int Q_W       = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

    localparam logic [REG_W-1:0] WIDTH_RST  = 11'd80;
    localparam logic [REG_W-1:0] HEIGHT_RST = 11'd25;

    localparam logic [MAG_W-1:0]  SIGN_EXT   = 9'd256;
    // x/6 == (x*171)>>10 for 0 <= x <= 256
    localparam logic [PROD_W-1:0] DIV6_MUL   = 17'd171;
    localparam int                DIV6_SHIFT = 10;

    localparam int HDR_LEFT   = 0;
    localparam int HDR_RIGHT  = 1;
    localparam int HDR_MIDDLE = 2;
    localparam int HDR_X_SIGN = 4;
    localparam int HDR_Y_SIGN = 5;

    typedef enum logic [1:0] {
        BYTE_HDR = 2'd0,
        BYTE_X   = 2'd1,
        BYTE_Y   = 2'd2
    } t_byte_idx;

endpackage

@@ rtl/ps2_mouse_packet_cursor.sv @@
// Channel   Direction  Signals                                 Moves
// input     in         i_in_valid / o_in_stall / i_data_byte   one mouse byte
// result    out        o_out_valid / i_out_stall / o_cursor_*  one packet result
// config    in         i_cfg_valid / o_cfg_ready / index,data  one register write
//
// One byte per cycle unless stalled: input register, then decode/clamp into the result register.
// A result is registered once the third byte of a packet leaves the input register.
// Reset (synchronous, active low) clears the byte counter and cursor, and sets sizes to 80 x 25.
// Input stalls only when a third byte waits and the result register is full and stalled.
// Config writes are always accepted.

`include "ps2_mouse_packet_cursor_macros.svh"

module ps2_mouse_packet_cursor
    import ps2mc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [BYTE_W-1:0]     i_data_byte,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_BITS-1:0] o_cursor_x,
    output logic [COORD_BITS-1:0] o_cursor_y,
    output logic [COORD_BITS-1:0] o_prev_x,
    output logic [COORD_BITS-1:0] o_prev_y,
    output logic                  o_left_button,
    output logic                  o_right_button,
    output logic                  o_middle_button,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [REG_W-1:0]      i_cfg_data
);

    localparam int WW = ((COORD_BITS > REG_W) ? COORD_BITS : REG_W) + 1;
    localparam logic [WW-1:0] CAP = {{(WW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

    logic [REG_W-1:0]      r_width, r_height;
    logic                  r_in_valid;
    logic [BYTE_W-1:0]     r_in_byte;
    t_byte_idx             r_byte_idx, n_byte_idx;
    logic [BYTE_W-1:0]     r_hdr, n_hdr;
    logic [BYTE_W-1:0]     r_x_move, n_x_move;
    logic [COORD_BITS-1:0] r_pos_x, n_pos_x;
    logic [COORD_BITS-1:0] r_pos_y, n_pos_y;

    logic                  in_accept, advance, load;
    logic [WW-1:0]         lim_x, lim_y;
    logic [Q_W-1:0]        q_x, q_y;

    function automatic logic [WW-1:0] size_limit(input logic [REG_W-1:0] size);
        logic [WW-1:0] lim;
        lim = (size == '0) ? '0 : WW'(size) - WW'(1);
        return (lim > CAP) ? CAP : lim;
    endfunction

    // magnitude of the 9-bit signed movement divided by 6, toward zero
    function automatic logic [Q_W-1:0] move_div6(input logic [BYTE_W-1:0] raw,
                                                 input logic neg);
        logic [MAG_W-1:0]  mag;
        logic [PROD_W-1:0] prod;
        mag  = neg ? (SIGN_EXT - MAG_W'(raw)) : MAG_W'(raw);
        prod = PROD_W'(mag) * DIV6_MUL;
        return prod[DIV6_SHIFT +: Q_W];
    endfunction

    function automatic logic [COORD_BITS-1:0] step_coord(input logic [COORD_BITS-1:0] old,
                                                         input logic [Q_W-1:0] q,
                                                         input logic up,
                                                         input logic [WW-1:0] hi);
        logic [WW-1:0] ext, qe, res;
        ext = WW'(old);
        qe  = WW'(q);
        if (up) begin
            res = ext + qe;
        end else begin
            res = (qe > ext) ? '0 : ext - qe;
        end
        if (res > hi) begin
            res = hi;
        end
        return res[COORD_BITS-1:0];
    endfunction

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign lim_x = size_limit(r_width);
    assign lim_y = size_limit(r_height);
    assign q_x   = move_div6(r_x_move, r_hdr[HDR_X_SIGN]);
    assign q_y   = move_div6(r_in_byte, r_hdr[HDR_Y_SIGN]);

    // only a Y byte needs room in the result register
    assign load       = r_in_valid && (r_byte_idx == BYTE_Y);
    assign advance    = r_in_valid && (!load || !o_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
        end
    end

    always_comb begin
        n_byte_idx = r_byte_idx;
        n_hdr      = r_hdr;
        n_x_move   = r_x_move;
        n_pos_x    = r_pos_x;
        n_pos_y    = r_pos_y;
        if (advance) begin
            unique case (r_byte_idx)
                BYTE_X: begin
                    n_x_move   = r_in_byte;
                    n_byte_idx = BYTE_Y;
                end
                BYTE_Y: begin
                    n_byte_idx = BYTE_HDR;
                    n_pos_x    = step_coord(r_pos_x, q_x, !r_hdr[HDR_X_SIGN], lim_x);
                    n_pos_y    = step_coord(r_pos_y, q_y, r_hdr[HDR_Y_SIGN], lim_y);
                end
                default: begin
                    n_hdr      = r_in_byte;
                    n_byte_idx = BYTE_X;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_idx <= BYTE_HDR;
            r_hdr      <= '0;
            r_x_move   <= '0;
            r_pos_x    <= '0;
            r_pos_y    <= '0;
        end else begin
            r_byte_idx <= n_byte_idx;
            r_hdr      <= n_hdr;
            r_x_move   <= n_x_move;
            r_pos_x    <= n_pos_x;
            r_pos_y    <= n_pos_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (advance && load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && load) begin
            o_cursor_x      <= n_pos_x;
            o_cursor_y      <= n_pos_y;
            o_prev_x        <= r_pos_x;
            o_prev_y        <= r_pos_y;
            o_left_button   <= r_hdr[HDR_LEFT];
            o_right_button  <= r_hdr[HDR_RIGHT];
            o_middle_button <= r_hdr[HDR_MIDDLE];
        end
    end

    `PMC_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall,
        r_in_valid && (r_byte_idx == BYTE_Y) && o_out_valid && i_out_stall)
    `PMC_ASSERT_NOW(a_cursor_in_range, i_clk, i_rst_n, o_out_valid,
        (WW'(o_cursor_x) <= lim_x) && (WW'(o_cursor_y) <= lim_y))
    `PMC_ASSERT_NEXT(a_prev_matches, i_clk, i_rst_n, advance && load,
        o_out_valid && (o_prev_x == $past(r_pos_x)) && (o_cursor_x == r_pos_x))

endmodule
